@@ hw/rtl/hsv_rgb_color_convert_macros.svh @@
// Assertion helpers shared by the checker.
`ifndef HSV_RGB_COLOR_CONVERT_MACROS_SVH
`define HSV_RGB_COLOR_CONVERT_MACROS_SVH

// Same-cycle implication, ignored while in reset.
`define HRC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hrc check failed");

// Next-cycle implication, ignored while in reset.
`define HRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hrc check failed");

// Next-cycle implication that also covers reset.
`define HRC_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("hrc reset check failed");

`endif

@@ hw/rtl/hrc_pkg.sv @@
package hrc_pkg;

  localparam int unsigned NUM_W = 28;
  localparam int unsigned DEN_W = 20;
  localparam int unsigned Q_W   = 9;
  localparam int unsigned CMP_W = DEN_W + Q_W;

  localparam int unsigned NUM_LANES   = 4;
  localparam int unsigned LANE_LVL    = 0;
  localparam int unsigned LANE_BASE   = 1;
  localparam int unsigned LANE_RISE   = 2;
  localparam int unsigned LANE_FALL   = 3;
  localparam int unsigned NUM_SECTORS = 6;

  localparam logic [8:0] HUE_MAX    = 9'd359;
  localparam logic [8:0] HUE_WRAP   = 9'd360;
  localparam logic [6:0] PCT_MAX    = 7'd100;
  localparam logic [5:0] SECTOR_DEG = 6'd60;

  localparam logic [DEN_W-1:0] DEN_PCT   = DEN_W'(100);
  localparam logic [DEN_W-1:0] DEN_BASE  = DEN_W'(10000);
  localparam logic [DEN_W-1:0] DEN_SLOPE = DEN_W'(600000);
  localparam logic [DEN_W-1:0] DEN_FULL  = DEN_W'(255);
  localparam logic [DEN_W-1:0] DEN_ONE   = DEN_W'(1);

  typedef enum logic {
    FUNC_HSV2RGB = 1'b0,
    FUNC_RGB2HSV = 1'b1
  } hrc_func_t;

  typedef struct packed {
    hrc_func_t  func;
    logic [8:0] hue_in;
    logic [6:0] sat_in;
    logic [6:0] val_in;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } hrc_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [8:0] hue_out;
    logic [6:0] sat_out;
    logic [6:0] val_out;
  } hrc_out_t;

  typedef struct packed {
    hrc_func_t  func;
    logic [2:0] sector;
    logic       sat_zero;
    logic       neg;
    logic       max_zero;
    logic       delta_zero;
    hrc_out_t   echo;
  } hrc_side_t;

  typedef struct packed {
    logic [NUM_LANES-1:0][NUM_W-1:0] num;
    logic [NUM_LANES-1:0][DEN_W-1:0] den;
    hrc_side_t                       side;
  } hrc_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } hrc_qstat_t;

endpackage

@@ hw/rtl/hrc_front.sv @@
module hrc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hrc_pkg::hrc_in_t  in_item,
  input  hrc_pkg::hrc_qstat_t qstat,
  output logic              push,
  output hrc_pkg::hrc_job_t job
);
  import hrc_pkg::*;

  logic        vld_r;
  hrc_side_t   side_r, side_nxt;
  logic [13:0] pb_r, pb_nxt, ps_r, ps_nxt;
  logic [5:0]  m_r, m_nxt;
  logic [7:0]  mx_r, mx_nxt, dl_r, dl_nxt;
  logic [10:0] xm_r, xm_nxt;

  logic [8:0]  h_c, sec_deg;
  logic [6:0]  s_c, v_c, s_inv;
  logic [2:0]  sec;
  logic [7:0]  r, g, b, mn;
  logic [NUM_W-1:0] b22, d22;

  assign in_stall = vld_r && qstat.full;
  assign push     = vld_r && !qstat.full;

  always_comb begin
    r = in_item.red_in;
    g = in_item.green_in;
    b = in_item.blue_in;
    h_c = (in_item.hue_in > HUE_MAX) ? HUE_MAX : in_item.hue_in;
    s_c = (in_item.sat_in > PCT_MAX) ? PCT_MAX : in_item.sat_in;
    v_c = (in_item.val_in > PCT_MAX) ? PCT_MAX : in_item.val_in;
    sec = '0;
    sec_deg = '0;
    for (int k = 1; k < NUM_SECTORS; k++) begin
      if (h_c >= 9'(k * int'(SECTOR_DEG))) begin
        sec = 3'(k);
        sec_deg = 9'(k * int'(SECTOR_DEG));
      end
    end
    m_nxt = 6'(h_c - sec_deg);
    s_inv = PCT_MAX - s_c;
    pb_nxt = 14'(s_inv) * 14'(v_c);
    ps_nxt = 14'(s_c) * 14'(v_c);

    mx_nxt = r;
    if (g > mx_nxt) mx_nxt = g;
    if (b > mx_nxt) mx_nxt = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dl_nxt = mx_nxt - mn;

    side_nxt.neg = 1'b0;
    if (r == mx_nxt) begin
      side_nxt.neg = g < b;
      xm_nxt = (g < b) ? 11'(b - g) : 11'(g - b);
    end else if (g == mx_nxt) begin
      xm_nxt = (11'(dl_nxt) << 1) + 11'(b) - 11'(r);
    end else begin
      xm_nxt = (11'(dl_nxt) << 2) + 11'(r) - 11'(g);
    end

    side_nxt.func           = in_item.func;
    side_nxt.sector         = sec;
    side_nxt.sat_zero       = (s_c == '0);
    side_nxt.max_zero       = (mx_nxt == '0);
    side_nxt.delta_zero     = (dl_nxt == '0);
    side_nxt.echo.red_out   = r;
    side_nxt.echo.green_out = g;
    side_nxt.echo.blue_out  = b;
    side_nxt.echo.hue_out   = h_c;
    side_nxt.echo.sat_out   = s_c;
    side_nxt.echo.val_out   = v_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      side_r <= side_nxt;
      pb_r   <= pb_nxt;
      ps_r   <= ps_nxt;
      m_r    <= m_nxt;
      mx_r   <= mx_nxt;
      dl_r   <= dl_nxt;
      xm_r   <= xm_nxt;
    end
  end

  // base and span scaled by 255
  assign b22 = (NUM_W'(pb_r) << 8) - NUM_W'(pb_r);
  assign d22 = (NUM_W'(ps_r) << 8) - NUM_W'(ps_r);

  always_comb begin
    job.side = side_r;
    if (side_r.func == FUNC_HSV2RGB) begin
      job.num[LANE_LVL]  = (NUM_W'(side_r.echo.val_out) << 8) - NUM_W'(side_r.echo.val_out);
      job.den[LANE_LVL]  = DEN_PCT;
      job.num[LANE_BASE] = b22;
      job.den[LANE_BASE] = DEN_BASE;
      job.num[LANE_RISE] = d22 * NUM_W'(m_r) + b22 * NUM_W'(SECTOR_DEG);
      job.den[LANE_RISE] = DEN_SLOPE;
      job.num[LANE_FALL] = d22 * NUM_W'(SECTOR_DEG - m_r) + b22 * NUM_W'(SECTOR_DEG);
      job.den[LANE_FALL] = DEN_SLOPE;
    end else begin
      job.num[LANE_LVL]  = NUM_W'(mx_r) * NUM_W'(PCT_MAX);
      job.den[LANE_LVL]  = DEN_FULL;
      job.num[LANE_BASE] = NUM_W'(dl_r) * NUM_W'(PCT_MAX);
      job.den[LANE_BASE] = DEN_W'(mx_r);
      job.num[LANE_RISE] = NUM_W'(xm_r) * NUM_W'(SECTOR_DEG);
      job.den[LANE_RISE] = DEN_W'(dl_r);
      job.num[LANE_FALL] = '0;
      job.den[LANE_FALL] = DEN_ONE;
    end
  end

endmodule

@@ hw/rtl/hrc_queue.sv @@
module hrc_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hrc_pkg::hrc_job_t   job_in,
  input  logic                pop,
  output hrc_pkg::hrc_job_t   job_out,
  output hrc_pkg::hrc_qstat_t qstat
);
  import hrc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hrc_job_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign qstat.full  = (cnt_r == CNT_W'(DEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign job_out     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= job_in;
    end
  end

endmodule

@@ hw/rtl/hrc_div.sv @@
module hrc_div (
  input  logic                     clk,
  input  logic                     en,
  input  logic [hrc_pkg::NUM_W-1:0] num,
  input  logic [hrc_pkg::DEN_W-1:0] den,
  output logic [hrc_pkg::Q_W-1:0]   q
);
  import hrc_pkg::*;

  logic [NUM_W-1:0] rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W];

  // restoring division, one quotient bit per stage, MSB first
  for (genvar i = 0; i < Q_W; i++) begin : g_stg
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   q_in;
    logic [CMP_W-1:0] den_sh;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign q_in   = q_r[i-1];
    end

    assign den_sh = CMP_W'(den_in) << (Q_W - 1 - i);
    assign ge     = CMP_W'(rem_in) >= den_sh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? rem_in - den_sh[NUM_W-1:0] : rem_in;
        den_r[i] <= den_in;
        q_r[i]   <= {q_in[Q_W-2:0], ge};
      end
    end
  end

  assign q = q_r[Q_W-1];

endmodule

@@ hw/rtl/hrc_back.sv @@
module hrc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  hrc_pkg::hrc_qstat_t qstat,
  input  hrc_pkg::hrc_job_t   job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output hrc_pkg::hrc_out_t   out_item
);
  import hrc_pkg::*;

  logic                en;
  logic [Q_W-1:0]      vld_r;
  hrc_side_t           side_r [Q_W];
  logic [Q_W-1:0]      quo [NUM_LANES];
  logic                out_valid_r;
  hrc_out_t            out_item_r, res;
  hrc_side_t           sd;
  logic [7:0]          top, base, rise, fall;

  assign en  = !(out_valid_r && out_stall);
  assign pop = en && !qstat.empty;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    hrc_div u_div (
      .clk (clk),
      .en  (en),
      .num (job.num[l]),
      .den (job.den[l]),
      .q   (quo[l])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[Q_W-2:0], pop};
      out_valid_r <= vld_r[Q_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= job.side;
      for (int i = 1; i < Q_W; i++) begin
        side_r[i] <= side_r[i-1];
      end
      out_item_r <= res;
    end
  end

  always_comb begin
    sd   = side_r[Q_W-1];
    top  = quo[LANE_LVL][7:0];
    base = quo[LANE_BASE][7:0];
    rise = quo[LANE_RISE][7:0];
    fall = quo[LANE_FALL][7:0];
    res  = sd.echo;
    if (sd.func == FUNC_HSV2RGB) begin
      if (sd.sat_zero) begin
        res.red_out   = top;
        res.green_out = top;
        res.blue_out  = top;
      end else begin
        unique case (sd.sector)
          3'd0: begin
            res.red_out = top;  res.green_out = rise; res.blue_out = base;
          end
          3'd1: begin
            res.red_out = fall; res.green_out = top;  res.blue_out = base;
          end
          3'd2: begin
            res.red_out = base; res.green_out = top;  res.blue_out = rise;
          end
          3'd3: begin
            res.red_out = base; res.green_out = fall; res.blue_out = top;
          end
          3'd4: begin
            res.red_out = rise; res.green_out = base; res.blue_out = top;
          end
          default: begin
            res.red_out = top;  res.green_out = base; res.blue_out = fall;
          end
        endcase
      end
    end else begin
      if (sd.max_zero) begin
        res.hue_out = '0;
        res.sat_out = '0;
        res.val_out = '0;
      end else begin
        res.val_out = quo[LANE_LVL][6:0];
        res.sat_out = quo[LANE_BASE][6:0];
        if (sd.delta_zero) begin
          res.hue_out = '0;
        end else if (sd.neg && quo[LANE_RISE] != '0) begin
          res.hue_out = HUE_WRAP - quo[LANE_RISE];
        end else begin
          res.hue_out = quo[LANE_RISE];
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ hw/rtl/hsv_rgb_color_convert.sv @@
// HSV <-> RGB color converter, one color per item.
// Input channel: in_valid / in_stall / in_item. in_item.func = 0 converts
// hue (0-359), saturation and value (0-100) to 8-bit red, green, blue;
// func = 1 converts red, green, blue to hue, saturation and value. Fields
// of the unused direction are echoed on the output; HSV inputs are clamped.
// Output channel: out_valid / out_stall / out_item, held while stalled.
// Throughput: one item per cycle, back to back, while neither in_stall nor out_stall holds the flow.
// Path from acceptance to out_valid when nothing is queued: classification
// and operand products in the front register, the job queue, the stages of
// the pipelined restoring dividers (one quotient bit per stage), then the
// output register.
// A QUEUE_DEPTH-entry job queue sits between the front and the divider
// pipeline. When out_stall and out_valid are both high the divider
// pipeline freezes, the queue fills, and in_stall rises once the queue is
// full and the front register holds an item.
// Reset (rst_n low, synchronous) empties the pipeline and queue; no
// results are pending afterwards.
module hsv_rgb_color_convert #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hrc_pkg::hrc_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output hrc_pkg::hrc_out_t out_item
);
  import hrc_pkg::*;

  hrc_qstat_t qstat;
  hrc_job_t   job_in, job_out;
  logic       push, pop;

  hrc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .qstat    (qstat),
    .push     (push),
    .job      (job_in)
  );

  hrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .job_in  (job_in),
    .pop     (pop),
    .job_out (job_out),
    .qstat   (qstat)
  );

  hrc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .job       (job_out),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

@@ hw/rtl/hrc_chk.sv @@
`include "hsv_rgb_color_convert_macros.svh"

module hrc_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input hrc_pkg::hrc_in_t  in_item,
  input logic              out_valid,
  input logic              out_stall,
  input hrc_pkg::hrc_out_t out_item
);
  import hrc_pkg::*;

  logic in_seen;
  assign in_seen = in_valid && (in_item.func == FUNC_HSV2RGB || in_item.func == FUNC_RGB2HSV);

  `HRC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))
  `HRC_ASSERT_IMPL(a_out_range, out_valid, out_item.hue_out <= HUE_MAX && out_item.sat_out <= PCT_MAX && out_item.val_out <= PCT_MAX)
  `HRC_ASSERT_RST(a_rst_clear, !rst_n, !out_valid && !in_stall)
  `HRC_ASSERT_IMPL(a_no_stall_idle, !in_seen && !out_valid, !in_stall)

endmodule

bind hsv_rgb_color_convert hrc_chk u_hrc_chk (.*);

@@ tb/hsv_rgb_color_convert_checker.sv @@
`timescale 1ns / 1ps

module hsv_rgb_color_convert_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  hrc_pkg::hrc_in_t  in_item,
  input  logic              out_valid,
  input  logic              out_stall,
  input  hrc_pkg::hrc_out_t out_item,
  output int                fail_count,
  output int                pending
);
  import hrc_pkg::*;

  hrc_out_t color_q[$];

  function automatic hrc_out_t convert_color(hrc_in_t it);
    hrc_out_t o;
    int h, s, v, tn, bn, top, base, m, up, down;
    int r, g, b, mx, mn, dl, t;
    o = '0;
    if (it.func == FUNC_HSV2RGB) begin
      h = (it.hue_in > 359) ? 359 : it.hue_in;
      s = (it.sat_in > 100) ? 100 : it.sat_in;
      v = (it.val_in > 100) ? 100 : it.val_in;
      tn = 25500 * v;
      bn = 255 * (100 - s) * v;
      top = tn / 10000;
      base = bn / 10000;
      m = h % 60;
      up = ((tn - bn) * m + 60 * bn) / 600000;
      down = ((tn - bn) * (60 - m) + 60 * bn) / 600000;
      if (s == 0) begin
        r = top; g = top; b = top;
      end else begin
        case (h / 60)
          0: begin r = top; g = up; b = base; end
          1: begin r = down; g = top; b = base; end
          2: begin r = base; g = top; b = up; end
          3: begin r = base; g = down; b = top; end
          4: begin r = up; g = base; b = top; end
          default: begin r = top; g = base; b = down; end
        endcase
      end
      o.red_out = 8'(r);
      o.green_out = 8'(g);
      o.blue_out = 8'(b);
      o.hue_out = 9'(h);
      o.sat_out = 7'(s);
      o.val_out = 7'(v);
    end else begin
      r = it.red_in; g = it.green_in; b = it.blue_in;
      o.red_out = it.red_in;
      o.green_out = it.green_in;
      o.blue_out = it.blue_in;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      dl = mx - mn;
      if (mx != 0) begin
        h = 0;
        if (dl != 0) begin
          if (r == mx) t = 60 * (g - b) / dl;
          else if (g == mx) t = 60 * (2 * dl + b - r) / dl;
          else t = 60 * (4 * dl + r - g) / dl;
          h = (t < 0) ? t + 360 : t;
        end
        o.hue_out = 9'(h);
        o.sat_out = 7'(dl * 100 / mx);
        o.val_out = 7'(mx * 100 / 255);
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin
    hrc_out_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (color_q.size() == 0) begin
          $error("unexpected item %h", out_item);
          fail_count <= fail_count + 1;
        end else begin
          e = color_q.pop_front();
          if (out_item !== e) begin
            if (out_item.red_out !== e.red_out)
              $error("red_out exp %0d got %0d", e.red_out, out_item.red_out);
            if (out_item.green_out !== e.green_out)
              $error("green_out exp %0d got %0d", e.green_out, out_item.green_out);
            if (out_item.blue_out !== e.blue_out)
              $error("blue_out exp %0d got %0d", e.blue_out, out_item.blue_out);
            if (out_item.hue_out !== e.hue_out)
              $error("hue_out exp %0d got %0d", e.hue_out, out_item.hue_out);
            if (out_item.sat_out !== e.sat_out)
              $error("sat_out exp %0d got %0d", e.sat_out, out_item.sat_out);
            if (out_item.val_out !== e.val_out)
              $error("val_out exp %0d got %0d", e.val_out, out_item.val_out);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) color_q.push_back(convert_color(in_item));
      pending <= color_q.size();
    end else begin
      fail_count <= 0;
      pending <= 0;
    end
  end
endmodule

@@ tb/hsv_rgb_color_convert_tb.sv @@
`timescale 1ns / 1ps

module hsv_rgb_color_convert_tb;
  import hrc_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  hrc_in_t  in_item;
  logic     out_valid;
  logic     out_stall;
  hrc_out_t out_item;
  int       fail_count;
  int       pending;
  int       idle_pct;
  int       stall_pct;

  hsv_rgb_color_convert u_dut (.*);

  hsv_rgb_color_convert_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_color(hrc_in_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic hrc_in_t hsv_item(int h, int s, int v);
    hrc_in_t it;
    it = hrc_in_t'($urandom());
    it.func = FUNC_HSV2RGB;
    it.hue_in = 9'(h);
    it.sat_in = 7'(s);
    it.val_in = 7'(v);
    return it;
  endfunction

  function automatic hrc_in_t rgb_item(int r, int g, int b);
    hrc_in_t it;
    it = hrc_in_t'($urandom());
    it.func = FUNC_RGB2HSV;
    it.red_in = 8'(r);
    it.green_in = 8'(g);
    it.blue_in = 8'(b);
    return it;
  endfunction

  initial begin
    hrc_in_t it;
    int waited;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_color(hsv_item(0, 100, 100));
    send_color(hsv_item(359, 100, 100));
    send_color(hsv_item(511, 127, 127));
    send_color(hsv_item(120, 0, 50));
    send_color(hsv_item(60, 100, 0));
    send_color(hsv_item(90, 50, 100));
    send_color(hsv_item(180, 75, 80));
    send_color(hsv_item(240, 1, 99));
    send_color(hsv_item(300, 100, 100));
    send_color(hsv_item(330, 33, 77));
    send_color(hsv_item(360, 101, 101));
    send_color(rgb_item(0, 0, 0));
    send_color(rgb_item(255, 255, 255));
    send_color(rgb_item(128, 128, 128));
    send_color(rgb_item(255, 0, 0));
    send_color(rgb_item(255, 0, 10));
    send_color(rgb_item(0, 255, 0));
    send_color(rgb_item(0, 0, 255));
    send_color(rgb_item(255, 255, 0));
    send_color(rgb_item(10, 200, 100));
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 19 : 55) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 19 : 55) : 0;
      for (int i = 0; i < 250; i++) begin
        it = hrc_in_t'({$urandom(), $urandom()});
        if ($urandom_range(9) != 0) begin
          it.hue_in = 9'($urandom_range(359));
          it.sat_in = 7'($urandom_range(100));
          it.val_in = 7'($urandom_range(100));
        end
        send_color(it);
      end
    end
    in_valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
